>>> hdl/vnu_pkg.sv
// Shared types and constants of the vector normalize unit.
package vnu_pkg;

    localparam int IN_W    = 24;            // component width, Q8.16 in, Q1.22 out
    localparam int HALF_W  = 24;            // half of a magnitude, one multiplier operand
    localparam int MAG_W   = 2 * HALF_W;    // magnitude of a component or cross product
    localparam int SUM_W   = 96;            // sum of three squared magnitudes
    localparam int ROOT_W  = SUM_W / 2;     // floor square root, one bit per stage
    localparam int REM_W   = ROOT_W + 2;    // square root partial remainder
    localparam int Q_W     = 23;            // unit quotient, integer bit plus 22 fraction bits
    localparam int LSQ_W   = 48;            // squared length output
    localparam int SHIFT_W = 22;            // Q2.44 to Q1.22
    localparam int DOT_W   = 2 * IN_W + 2;  // sum of three products

    localparam logic [IN_W-1:0] UNIT_ONE = IN_W'(4194304);

    typedef enum logic [1:0] {
        OP_NORM  = 2'd0,
        OP_CROSS = 2'd1,
        OP_COS   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Two vectors as sign and magnitude, vector 0 first.
    typedef struct packed {
        op_t                            op;
        logic [1:0][2:0]                neg;
        logic [1:0][2:0][MAG_W-1:0]     mag;
    } vec_pair_t;

    typedef struct packed {
        op_t             op;
        logic [1:0][2:0] neg;
    } hdr_t;

    // Two unit vectors plus the length figures of vector 0.
    typedef struct packed {
        op_t                        op;
        logic [1:0][2:0][IN_W-1:0]  unit;
        logic [LSQ_W-1:0]           len_sq;
        logic [IN_W-1:0]            len;
    } unit_pair_t;

    typedef struct packed {
        op_t                   op;
        logic [2:0][IN_W-1:0]  unit;
        logic [LSQ_W-1:0]      len_sq;
        logic [IN_W-1:0]       len;
        logic [IN_W-1:0]       cosine;
    } dot_item_t;

endpackage

>>> hdl/vnu_front.sv
// Input register, cross product and selection of the vectors to normalize.
module vnu_front import vnu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [1:0]             op,
    input  logic signed [IN_W-1:0] a_x,
    input  logic signed [IN_W-1:0] a_y,
    input  logic signed [IN_W-1:0] a_z,
    input  logic signed [IN_W-1:0] b_x,
    input  logic signed [IN_W-1:0] b_y,
    input  logic signed [IN_W-1:0] b_z,
    output logic                   out_valid,
    output vec_pair_t              out_item
);

    logic                      v0_reg, v1_reg, v2_reg;
    op_t                       op0_reg, op1_reg;
    logic signed [IN_W-1:0]    a0_reg [3];
    logic signed [IN_W-1:0]    b0_reg [3];
    logic signed [IN_W-1:0]    a1_reg [3];
    logic signed [IN_W-1:0]    b1_reg [3];
    logic signed [MAG_W-1:0]   p_reg  [6];
    logic signed [MAG_W-1:0]   p_next [6];
    logic signed [MAG_W:0]     val0 [3];
    logic signed [MAG_W:0]     val1 [3];
    logic signed [MAG_W:0]     neg0 [3];
    logic signed [MAG_W:0]     neg1 [3];
    vec_pair_t                 item_next;
    vec_pair_t                 item_reg;

    always_comb
    begin
        p_next[0] = a0_reg[1] * b0_reg[2];
        p_next[1] = a0_reg[2] * b0_reg[1];
        p_next[2] = a0_reg[2] * b0_reg[0];
        p_next[3] = a0_reg[0] * b0_reg[2];
        p_next[4] = a0_reg[0] * b0_reg[1];
        p_next[5] = a0_reg[1] * b0_reg[0];
    end

    always_comb
    begin
        item_next    = '0;
        item_next.op = op1_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (op1_reg == OP_CROSS)
            begin
                val0[c] = (MAG_W+1)'(p_reg[2*c]) - (MAG_W+1)'(p_reg[2*c+1]);
            end
            else
            begin
                val0[c] = (MAG_W+1)'(a1_reg[c]);
            end
            val1[c] = (MAG_W+1)'(b1_reg[c]);
            neg0[c] = -val0[c];
            neg1[c] = -val1[c];
            item_next.neg[0][c] = val0[c][MAG_W];
            item_next.neg[1][c] = val1[c][MAG_W];
            item_next.mag[0][c] = val0[c][MAG_W] ? neg0[c][MAG_W-1:0] : val0[c][MAG_W-1:0];
            item_next.mag[1][c] = val1[c][MAG_W] ? neg1[c][MAG_W-1:0] : val1[c][MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg   <= op_t'(op);
            a0_reg[0] <= a_x;
            a0_reg[1] <= a_y;
            a0_reg[2] <= a_z;
            b0_reg[0] <= b_x;
            b0_reg[1] <= b_y;
            b0_reg[2] <= b_z;
            op1_reg   <= op0_reg;
            a1_reg    <= a0_reg;
            b1_reg    <= b0_reg;
            p_reg     <= p_next;
            item_reg  <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/vnu_norm.sv
// Squared length, bit-serial square root and quotient pipelines for two vectors.
module vnu_norm import vnu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  vec_pair_t  in_item,
    output logic       out_valid,
    output unit_pair_t out_item
);

    // Squares are split into three half-width partial products.
    logic [MAG_W-1:0]  hh_reg [2][3];
    logic [MAG_W-1:0]  hl_reg [2][3];
    logic [MAG_W-1:0]  ll_reg [2][3];
    logic [SUM_W-1:0]  sq_reg [2][3];
    logic [SUM_W-1:0]  sum_reg [2];
    vec_pair_t         p1_reg, p2_reg, p3_reg;
    logic [2:0]        vsq_reg;

    // Square root, one result bit per stage.
    logic [REM_W-1:0]  rem_reg  [2][ROOT_W];
    logic [REM_W-1:0]  rem_next [2][ROOT_W];
    logic [ROOT_W-1:0] res_reg  [2][ROOT_W];
    logic [ROOT_W-1:0] res_next [2][ROOT_W];
    logic [SUM_W-1:0]  s_reg    [2][ROOT_W];
    logic [SUM_W-1:0]  s_next   [2][ROOT_W];
    vec_pair_t         rp_reg   [ROOT_W];
    logic              vrt_reg  [ROOT_W];

    // Restoring division, one quotient bit per stage.
    logic [MAG_W-1:0]  r_reg    [2][3][Q_W];
    logic [MAG_W-1:0]  r_next   [2][3][Q_W];
    logic [Q_W-1:0]    q_reg    [2][3][Q_W];
    logic [Q_W-1:0]    q_next   [2][3][Q_W];
    logic [ROOT_W-1:0] d_reg    [2][Q_W];
    logic [ROOT_W-1:0] d_next   [2][Q_W];
    hdr_t              hd_reg   [Q_W];
    hdr_t              hd_next  [Q_W];
    logic [LSQ_W-1:0]  lsq_reg  [Q_W];
    logic [LSQ_W-1:0]  lsq_next [Q_W];
    logic [IN_W-1:0]   len_reg  [Q_W];
    logic [IN_W-1:0]   len_next [Q_W];
    logic              vdv_reg  [Q_W];

    unit_pair_t        out_next;
    unit_pair_t        out_reg;
    logic              vout_reg;

    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] res_in;
    logic [SUM_W-1:0]  s_in;
    logic              rt_ge;
    logic [MAG_W:0]    r_sh, r_dif, d_ext;
    logic [Q_W-1:0]    q_in;
    logic              ge;
    logic [IN_W-1:0]   qmag;

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                if (i == 0)
                begin
                    rem_in = '0;
                    res_in = '0;
                    s_in   = sum_reg[v];
                end
                else
                begin
                    rem_in = rem_reg[v][i-1];
                    res_in = res_reg[v][i-1];
                    s_in   = s_reg[v][i-1];
                end
                rem_sh = {rem_in[REM_W-3:0], s_in[2*(ROOT_W-1-i) +: 2]};
                trial  = {res_in, 2'b01};
                rt_ge  = (rem_sh >= trial);
                rem_next[v][i] = rt_ge ? rem_sh - trial : rem_sh;
                res_next[v][i] = {res_in[ROOT_W-2:0], rt_ge};
                s_next[v][i]   = s_in;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < Q_W; j++)
        begin
            if (j == 0)
            begin
                hd_next[j].op  = rp_reg[ROOT_W-1].op;
                hd_next[j].neg = rp_reg[ROOT_W-1].neg;
                lsq_next[j]    = s_reg[0][ROOT_W-1][LSQ_W-1:0];
                len_next[j]    = res_reg[0][ROOT_W-1][IN_W-1:0];
            end
            else
            begin
                hd_next[j]  = hd_reg[j-1];
                lsq_next[j] = lsq_reg[j-1];
                len_next[j] = len_reg[j-1];
            end
            for (int v = 0; v < 2; v++)
            begin
                d_next[v][j] = (j == 0) ? res_reg[v][ROOT_W-1] : d_reg[v][j-1];
                d_ext = {1'b0, d_next[v][j]};
                for (int c = 0; c < 3; c++)
                begin
                    if (j == 0)
                    begin
                        r_sh = {1'b0, rp_reg[ROOT_W-1].mag[v][c]};
                        q_in = '0;
                    end
                    else
                    begin
                        r_sh = {r_reg[v][c][j-1], 1'b0};
                        q_in = q_reg[v][c][j-1];
                    end
                    ge    = (r_sh >= d_ext);
                    r_dif = r_sh - d_ext;
                    r_next[v][c][j] = ge ? r_dif[MAG_W-1:0] : r_sh[MAG_W-1:0];
                    q_next[v][c][j] = {q_in[Q_W-2:0], ge};
                end
            end
        end
    end

    always_comb
    begin
        out_next        = '0;
        out_next.op     = hd_reg[Q_W-1].op;
        out_next.len_sq = lsq_reg[Q_W-1];
        out_next.len    = len_reg[Q_W-1];
        for (int v = 0; v < 2; v++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                qmag = {1'b0, q_reg[v][c][Q_W-1]};
                // A zero-length vector has a zero unit vector.
                if (d_reg[v][Q_W-1] == '0)
                begin
                    out_next.unit[v][c] = '0;
                end
                else if (hd_reg[Q_W-1].neg[v][c])
                begin
                    out_next.unit[v][c] = -qmag;
                end
                else
                begin
                    out_next.unit[v][c] = qmag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsq_reg  <= '0;
            vout_reg <= 1'b0;
            for (int i = 0; i < ROOT_W; i++)
            begin
                vrt_reg[i] <= 1'b0;
            end
            for (int j = 0; j < Q_W; j++)
            begin
                vdv_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vsq_reg <= {vsq_reg[1:0], in_valid};
            vrt_reg[0] <= vsq_reg[2];
            for (int i = 1; i < ROOT_W; i++)
            begin
                vrt_reg[i] <= vrt_reg[i-1];
            end
            vdv_reg[0] <= vrt_reg[ROOT_W-1];
            for (int j = 1; j < Q_W; j++)
            begin
                vdv_reg[j] <= vdv_reg[j-1];
            end
            vout_reg <= vdv_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= in_item;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            for (int v = 0; v < 2; v++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    hh_reg[v][c] <= in_item.mag[v][c][MAG_W-1:HALF_W]
                                  * in_item.mag[v][c][MAG_W-1:HALF_W];
                    hl_reg[v][c] <= in_item.mag[v][c][MAG_W-1:HALF_W]
                                  * in_item.mag[v][c][HALF_W-1:0];
                    ll_reg[v][c] <= in_item.mag[v][c][HALF_W-1:0]
                                  * in_item.mag[v][c][HALF_W-1:0];
                    sq_reg[v][c] <= {hh_reg[v][c], {MAG_W{1'b0}}}
                                  + {{(HALF_W-1){1'b0}}, hl_reg[v][c], {(HALF_W+1){1'b0}}}
                                  + {{MAG_W{1'b0}}, ll_reg[v][c]};
                end
                sum_reg[v] <= sq_reg[v][0] + sq_reg[v][1] + sq_reg[v][2];
            end
            rp_reg[0] <= p3_reg;
            for (int i = 1; i < ROOT_W; i++)
            begin
                rp_reg[i] <= rp_reg[i-1];
            end
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            s_reg    <= s_next;
            r_reg    <= r_next;
            q_reg    <= q_next;
            d_reg    <= d_next;
            hd_reg   <= hd_next;
            lsq_reg  <= lsq_next;
            len_reg  <= len_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid = vout_reg;
    assign out_item  = out_reg;

endmodule

>>> hdl/vnu_dot.sv
// Dot product of the two unit vectors with truncation and saturation.
module vnu_dot import vnu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  unit_pair_t in_item,
    output logic       out_valid,
    output dot_item_t  out_item
);

    logic signed [2*IN_W-1:0] prod_reg [3];
    unit_pair_t               p1_reg;
    logic                     v1_reg, v2_reg;
    logic signed [DOT_W-1:0]  dsum;
    logic [DOT_W-1:0]         dmag;
    logic [DOT_W-SHIFT_W-1:0] dshift;
    logic [IN_W-1:0]          cmag;
    dot_item_t                item_next;
    dot_item_t                item_reg;

    always_comb
    begin
        dsum = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        dmag = dsum[DOT_W-1] ? -dsum : dsum;
        dshift = dmag[DOT_W-1:SHIFT_W];
        cmag = (dshift > (DOT_W-SHIFT_W)'(UNIT_ONE)) ? UNIT_ONE : dshift[IN_W-1:0];
        item_next.op     = p1_reg.op;
        item_next.unit   = p1_reg.unit[0];
        item_next.len_sq = p1_reg.len_sq;
        item_next.len    = p1_reg.len;
        item_next.cosine = dsum[DOT_W-1] ? -cmag : cmag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= $signed(in_item.unit[0][c]) * $signed(in_item.unit[1][c]);
            end
            p1_reg   <= in_item;
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

>>> hdl/vector_normalize_unit.sv
// Top level of the vector normalize unit: front end, normalizer, dot product, output register.
//
//   channel   valid          stall          payload
//   item      item_valid     item_stall     op, a_x, a_y, a_z, b_x, b_y, b_z
//   result    result_valid   result_stall   length_sq, length, unit_x/y/z, cosine
//
// One word enters per cycle and one result word leaves per cycle while no held result
// is stalled. The pipeline has three front stages, three squaring stages, 48 square root
// stages (one root bit each), 23 divider stages (one quotient bit each), the
// normalizer output stage, two dot product stages and the output register.
// Reset clears only the valid bits. A stall on the result side while a result is held
// freezes every stage at once, so no word is lost or repeated; while the output register is
// empty or being taken, every stage advances by one each cycle.
module vector_normalize_unit import vnu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               op,
    input  logic signed [IN_W-1:0]   a_x,
    input  logic signed [IN_W-1:0]   a_y,
    input  logic signed [IN_W-1:0]   a_z,
    input  logic signed [IN_W-1:0]   b_x,
    input  logic signed [IN_W-1:0]   b_y,
    input  logic signed [IN_W-1:0]   b_z,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [LSQ_W-1:0]         length_sq,
    output logic [IN_W-1:0]          length,
    output logic signed [IN_W-1:0]   unit_x,
    output logic signed [IN_W-1:0]   unit_y,
    output logic signed [IN_W-1:0]   unit_z,
    output logic signed [IN_W-1:0]   cosine
);

    logic       en;
    logic       front_valid, norm_valid, dot_valid;
    vec_pair_t  front_item;
    unit_pair_t norm_item;
    dot_item_t  dot_item;

    logic                   result_valid_reg;
    logic [LSQ_W-1:0]       length_sq_reg, length_sq_next;
    logic [IN_W-1:0]        length_reg, length_next;
    logic [2:0][IN_W-1:0]   unit_reg, unit_next;
    logic [IN_W-1:0]        cosine_reg, cosine_next;

    // The whole pipeline advances unless a held result is being stalled.
    assign en         = !result_valid_reg || !result_stall;
    assign item_stall = !en;

    vnu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .op        (op),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    vnu_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (norm_valid),
        .out_item  (norm_item)
    );

    vnu_dot u_dot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .in_item   (norm_item),
        .out_valid (dot_valid),
        .out_item  (dot_item)
    );

    // Each operation shows only its own fields; the rest read as zero.
    always_comb
    begin
        length_sq_next = '0;
        length_next    = '0;
        unit_next      = '0;
        cosine_next    = '0;
        case (dot_item.op)
            OP_NORM:
            begin
                length_sq_next = dot_item.len_sq;
                length_next    = dot_item.len;
                unit_next      = dot_item.unit;
            end
            OP_CROSS:
            begin
                unit_next = dot_item.unit;
            end
            OP_COS:
            begin
                cosine_next = dot_item.cosine;
            end
            default:
            begin
                unit_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= dot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            length_sq_reg <= length_sq_next;
            length_reg    <= length_next;
            unit_reg      <= unit_next;
            cosine_reg    <= cosine_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign length_sq    = length_sq_reg;
    assign length       = length_reg;
    assign unit_x       = unit_reg[0];
    assign unit_y       = unit_reg[1];
    assign unit_z       = unit_reg[2];
    assign cosine       = cosine_reg;

endmodule

>>> tb/sv/vector_normalize_unit_tb.sv
// Self-checking testbench of the vector normalize unit with directed and random words.
`timescale 1ns / 100ps

module vector_normalize_unit_tb;
    import vnu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 300;    // well beyond the pipeline depth, so it fills up
    localparam int DRAIN_WAIT  = 120;    // longer than the pipeline latency
    localparam int RANDOM_WORDS = 950;

    // One input word and one result word as the testbench sees them.
    typedef struct {
        op_t op;
        logic signed [IN_W-1:0] ax, ay, az, bx, by, bz;
    } vec_word_t;

    typedef struct {
        logic [LSQ_W-1:0] len_sq;
        logic [IN_W-1:0]  len;
        logic [IN_W-1:0]  ux, uy, uz;
        logic [IN_W-1:0]  cosv;
    } result_word_t;

    // A directed row: the word, and where obvious, the result typed in by hand.
    typedef struct {
        vec_word_t    word;
        bit           typed;
        result_word_t want;
    } row_t;

    // Unit vector of one normalization plus the figures it came from.
    typedef struct {
        logic [SUM_W-1:0]  sum;
        logic [ROOT_W-1:0] root;
        longint            u0, u1, u2;
    } norm_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] op = '0;
    logic signed [IN_W-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [IN_W-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [LSQ_W-1:0] length_sq;
    logic [IN_W-1:0] length;
    logic signed [IN_W-1:0] unit_x, unit_y, unit_z, cosine;

    result_word_t expected_results[$];
    row_t         directed_rows[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_request = 0;
    int           hold_left = 0;

    vector_normalize_unit dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .op(op), .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .length_sq(length_sq), .length(length),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .cosine(cosine)
    );

    always #5 clk = ~clk;

    // The run is bounded by a plain cycle counter, so a hang ends in a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Floor square root of a 96-bit sum, one root bit per pass from the top.
    function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] sum);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        root = '0;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            trial = root | (ROOT_W'(1) << i);
            if (SUM_W'(trial) * SUM_W'(trial) <= sum)
                root = trial;
        end
        return root;
    endfunction

    // One Q1.22 component: the magnitude over the length, truncated toward zero.
    function automatic longint unit_component(longint c, logic [ROOT_W-1:0] root);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quot;
        if (root == 0)
            return 0;
        mag  = (c < 0) ? SUM_W'(-c) : SUM_W'(c);
        quot = (mag << SHIFT_W) / SUM_W'(root);
        return (c < 0) ? -longint'(quot) : longint'(quot);
    endfunction

    function automatic norm_t normalize(longint cx, longint cy, longint cz);
        norm_t n;
        logic [SUM_W-1:0] mx, my, mz;
        mx = (cx < 0) ? SUM_W'(-cx) : SUM_W'(cx);
        my = (cy < 0) ? SUM_W'(-cy) : SUM_W'(cy);
        mz = (cz < 0) ? SUM_W'(-cz) : SUM_W'(cz);
        n.sum  = mx * mx + my * my + mz * mz;
        n.root = floor_root(n.sum);
        n.u0   = unit_component(cx, n.root);
        n.u1   = unit_component(cy, n.root);
        n.u2   = unit_component(cz, n.root);
        return n;
    endfunction

    // Result of one word: the cross product is kept exact before it is normalized,
    // and the cosine is truncated toward zero and clamped to plus or minus one.
    function automatic result_word_t vector_result(vec_word_t w);
        result_word_t r;
        norm_t na, nb;
        longint ax, ay, az, bx, by, bz, dot, cosv;
        ax = w.ax; ay = w.ay; az = w.az;
        bx = w.bx; by = w.by; bz = w.bz;
        r = '{default: '0};
        case (w.op)
            OP_NORM:
            begin
                na = normalize(ax, ay, az);
                r.len_sq = na.sum[LSQ_W-1:0];
                r.len    = na.root[IN_W-1:0];
                r.ux = IN_W'(na.u0); r.uy = IN_W'(na.u1); r.uz = IN_W'(na.u2);
            end
            OP_CROSS:
            begin
                na = normalize(ay * bz - az * by, az * bx - ax * bz, ax * by - ay * bx);
                r.ux = IN_W'(na.u0); r.uy = IN_W'(na.u1); r.uz = IN_W'(na.u2);
            end
            OP_COS:
            begin
                na = normalize(ax, ay, az);
                nb = normalize(bx, by, bz);
                dot = na.u0 * nb.u0 + na.u1 * nb.u1 + na.u2 * nb.u2;
                cosv = (dot >= 0) ? (dot >>> SHIFT_W) : -((-dot) >>> SHIFT_W);
                if (cosv > 4194304)
                    cosv = 4194304;
                if (cosv < -4194304)
                    cosv = -4194304;
                r.cosv = IN_W'(cosv);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [LSQ_W-1:0] got, logic [LSQ_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h, expected %h", cycle_count, field, got, want);
        error_count++;
    endtask

    // Results are sampled at the falling edge: the values then hold until the
    // rising edge that takes them, so the check is free of races.
    always @(negedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result word at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (length_sq !== want.len_sq) report_mismatch("length_sq", length_sq, want.len_sq);
                if (length !== want.len)       report_mismatch("length", length, want.len);
                if (unit_x !== want.ux)        report_mismatch("unit_x", unit_x, want.ux);
                if (unit_y !== want.uy)        report_mismatch("unit_y", unit_y, want.uy);
                if (unit_z !== want.uz)        report_mismatch("unit_z", unit_z, want.uz);
                if (cosine !== want.cosv)      report_mismatch("cosine", cosine, want.cosv);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one word, with random idle cycles in front, and wait until it is taken.
    task automatic send_word(vec_word_t w, bit typed, result_word_t want);
        bit stalled;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op  <= w.op;
        a_x <= w.ax; a_y <= w.ay; a_z <= w.az;
        b_x <= w.bx; b_y <= w.by; b_z <= w.bz;
        do
        begin
            @(negedge clk);
            stalled = item_stall;
            @(posedge clk);
        end
        while (stalled);
        expected_results.push_back(typed ? want : vector_result(w));
    endtask

    function automatic logic signed [IN_W-1:0] random_component();
        case ($urandom_range(3))
            0: return IN_W'($urandom);                                   // full range
            1: return IN_W'($signed($urandom_range(131072)) - 65536);    // within plus or minus 1.0
            2: return IN_W'($signed($urandom_range(511)) - 256);         // tiny, coarse root
            default: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
        endcase
    endfunction

    function automatic vec_word_t random_word();
        vec_word_t w;
        int pick;
        pick = $urandom_range(99);
        w.op = (pick < 6) ? OP_NONE : op_t'(pick % 3);
        w.ax = random_component(); w.ay = random_component(); w.az = random_component();
        w.bx = random_component(); w.by = random_component(); w.bz = random_component();
        // Zero vectors and parallel operands now and then, for the zero-length cases.
        case ($urandom_range(9))
            0: begin w.ax = '0; w.ay = '0; w.az = '0; end
            1: begin w.bx = '0; w.by = '0; w.bz = '0; end
            2: begin w.bx = w.ax; w.by = w.ay; w.bz = w.az; end
            3: begin w.bx = -w.ax; w.by = -w.ay; w.bz = -w.az; end
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_row(op_t o, int ax, int ay, int az, int bx, int by, int bz,
                           bit typed, result_word_t want);
        row_t r;
        r.word.op = o;
        r.word.ax = IN_W'(ax); r.word.ay = IN_W'(ay); r.word.az = IN_W'(az);
        r.word.bx = IN_W'(bx); r.word.by = IN_W'(by); r.word.bz = IN_W'(bz);
        r.typed = typed;
        r.want = want;
        directed_rows.push_back(r);
    endtask

    initial
    begin
        result_word_t zero_res, x_unit, x_cos;
        zero_res = '{default: '0};
        x_unit = zero_res;
        x_unit.len_sq = 48'h1_0000_0000;     // 1.0 squared in Q16.32
        x_unit.len    = 24'h010000;
        x_unit.ux     = UNIT_ONE;
        x_cos = zero_res;
        x_cos.cosv = UNIT_ONE;

        // Directed part: zero vectors, unit axes, extremes of the components,
        // parallel and opposite operands, and the undefined operation.
        add_row(OP_NORM,  0, 0, 0, 0, 0, 0, 1, zero_res);
        add_row(OP_CROSS, 0, 0, 0, 5, 6, 7, 1, zero_res);
        add_row(OP_COS,   0, 0, 0, 65536, 0, 0, 1, zero_res);
        add_row(OP_COS,   65536, 0, 0, 0, 0, 0, 1, zero_res);
        add_row(OP_NORM,  65536, 0, 0, 0, 0, 0, 1, x_unit);
        add_row(OP_COS,   65536, 0, 0, 65536, 0, 0, 1, x_cos);
        add_row(OP_CROSS, 65536, 0, 0, 0, 65536, 0, 0, zero_res);
        add_row(OP_CROSS, 65536, 0, 0, 131072, 0, 0, 1, zero_res);   // parallel
        add_row(OP_NONE, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 1, zero_res);
        add_row(OP_NORM, -8388608, -8388608, -8388608, 0, 0, 0, 0, zero_res);
        add_row(OP_NORM,  8388607, 8388607, 8388607, 0, 0, 0, 0, zero_res);
        add_row(OP_NORM,  1, 0, 0, 0, 0, 0, 0, zero_res);
        add_row(OP_NORM, -1, -1, 1, 0, 0, 0, 0, zero_res);
        add_row(OP_CROSS, 8388607, -8388608, 1, -8388608, 1, 8388607, 0, zero_res);
        add_row(OP_CROSS, -8388608, -8388608, 0, 8388607, -8388608, 0, 0, zero_res);
        add_row(OP_COS,   8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0, zero_res);
        add_row(OP_COS,   8388607, 0, 0, 8388607, 0, 0, 0, zero_res);
        add_row(OP_COS,   3, 4, 0, -4, 3, 0, 0, zero_res);
        add_row(OP_COS,   1, 1, 1, 8388607, 8388607, 8388607, 0, zero_res);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Three idling phases; the first opens with a long hold-off on the result
        // side while words keep coming, so the pipeline backs up to the input.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 14 : 0;
            if (phase == 0)
                hold_request = LONG_HOLD;
            for (int n = 0; n < RANDOM_WORDS / 3; n++)
                send_word(random_word(), 0, zero_res);
            // The sender pauses here until every expected word has come back.
            item_valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
